// ===== hdl/sfr_pkg.sv =====
// Package for the streaming find-and-replace block.
// Holds the default sizes, the interface widths and the job sizing function.
// Depends on nothing.
package sfr_pkg;

    localparam int DEF_MAX_TARGET      = 8;
    localparam int DEF_MAX_REPLACEMENT = 8;
    localparam int QUEUE_DEPTH         = 4;
    localparam int CFG_INDEX_W         = 4;
    localparam int CFG_DATA_W          = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_BYTES       = 4'd0,
        REG_TARGET_LENGTH      = 4'd1,
        REG_REPLACEMENT_BYTES  = 4'd2,
        REG_REPLACEMENT_LENGTH = 4'd3
    } t_cfg_reg;

    // A job holds either the replacement or the window, whichever is longer.
    function automatic int job_slots(input int mt, input int mr);
        return (mt > mr) ? mt : mr;
    endfunction

endpackage

// ===== hdl/sfr_ifs.sv =====
// Channel interfaces of the streaming find-and-replace block.
// Depends on sfr_pkg for the configuration port widths.
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_last;

    modport source(output valid, output in_byte, output stream_last, input ready);
    modport sink(input valid, input in_byte, input stream_last, output ready);
endinterface

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_last;
    logic       stream_end;

    modport source(output valid, output out_byte, output byte_present, output run_last,
                   output stream_end, input ready);
    modport sink(input valid, input out_byte, input byte_present, input run_last,
                 input stream_end, output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/sfr_front.sv =====
// Front part: configuration registers, pending window and combinational matcher.
// Each accepted byte with output or stream_last is one job of up to SLOTS bytes.
// Depends on sfr_pkg and the channel interfaces.
module sfr_front import sfr_pkg::*; #(
    parameter int  MAX_TARGET      = DEF_MAX_TARGET,
    parameter int  MAX_REPLACEMENT = DEF_MAX_REPLACEMENT,
    localparam int SLOTS           = job_slots(MAX_TARGET, MAX_REPLACEMENT),
    localparam int CW              = $clog2(MAX_TARGET + 1),
    localparam int JCW             = $clog2(SLOTS + 1),
    localparam int EXT             = MAX_TARGET + SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sfr_in_if.sink             i_in,
    sfr_cfg_if.sink            i_cfg,
    input  logic               i_q_ready,
    output logic               o_push,
    output logic [SLOTS*8-1:0] o_job_bytes,
    output logic [JCW-1:0]     o_job_cnt,
    output logic               o_job_last
);

    logic [63:0]   r_tbytes;
    logic [3:0]    r_tlen;
    logic [63:0]   r_rbytes;
    logic [3:0]    r_rlen;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [7:0]    r_win [MAX_TARGET];
    logic [7:0]    n_win [MAX_TARGET];

    logic [7:0]        win_ext [EXT];
    logic [3:0]        tlen4;
    logic [3:0]        rlen4;
    logic [CW-1:0]     tlen_eff;
    logic [CW-1:0]     cnt_new;
    logic [CW-1:0]     shift;
    logic [CW-1:0]     rem;
    logic [MAX_TARGET:0] ok;
    logic              match;
    logic              last;
    logic              accept;

    assign i_in.ready  = i_q_ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_q_ready;
    assign last        = i_in.stream_last;

    always_comb begin
        tlen4 = r_tlen;
        if (r_tlen == 4'd0) begin
            tlen4 = 4'd1;
        end else if (r_tlen > 4'(MAX_TARGET)) begin
            tlen4 = 4'(MAX_TARGET);
        end
        tlen_eff = CW'(tlen4);
        rlen4    = (r_rlen > 4'(MAX_REPLACEMENT)) ? 4'(MAX_REPLACEMENT) : r_rlen;
        cnt_new  = r_cnt + 1'b1;

        // The new byte lands just behind the pending bytes.
        for (int i = 0; i < MAX_TARGET; i++) begin
            win_ext[i] = (CW'(i) == r_cnt) ? i_in.in_byte : r_win[i];
        end
        for (int i = MAX_TARGET; i < EXT; i++) begin
            win_ext[i] = 8'd0;
        end

        // Dropping s bytes from the front must leave a prefix of the target.
        for (int s = 0; s <= MAX_TARGET; s++) begin
            ok[s] = (CW'(s) <= cnt_new) && ((cnt_new - CW'(s)) <= tlen_eff);
            for (int i = 0; i < MAX_TARGET; i++) begin
                if ((CW'(i) < (cnt_new - CW'(s))) && (win_ext[s+i] != r_tbytes[8*i +: 8])) begin
                    ok[s] = 1'b0;
                end
            end
        end

        shift = cnt_new;
        for (int s = MAX_TARGET; s >= 0; s--) begin
            if (ok[s]) begin
                shift = CW'(s);
            end
        end
        rem   = cnt_new - shift;
        match = (rem == tlen_eff);

        for (int j = 0; j < SLOTS; j++) begin
            o_job_bytes[8*j +: 8] = match ? r_rbytes[8*j +: 8] : win_ext[j];
        end
        if (match) begin
            o_job_cnt = JCW'(rlen4);
        end else if (last) begin
            o_job_cnt = JCW'(cnt_new);
        end else begin
            o_job_cnt = JCW'(shift);
        end
        o_job_last = last;

        for (int i = 0; i < MAX_TARGET; i++) begin
            n_win[i] = win_ext[i];
            for (int s = 0; s <= MAX_TARGET; s++) begin
                if (CW'(s) == shift) begin
                    n_win[i] = win_ext[i+s];
                end
            end
        end
        n_cnt = (match || last) ? '0 : rem;
    end

    assign o_push = accept && ((o_job_cnt != '0) || last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_tbytes <= '0;
            r_tlen   <= 4'd1;
            r_rbytes <= '0;
            r_rlen   <= 4'd0;
        end else begin
            if (accept) begin
                r_cnt <= n_cnt;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_TARGET_BYTES: begin
                        r_tbytes <= i_cfg.data;
                        r_cnt    <= '0;
                    end
                    REG_TARGET_LENGTH: begin
                        r_tlen <= i_cfg.data[3:0];
                        r_cnt  <= '0;
                    end
                    REG_REPLACEMENT_BYTES: begin
                        r_rbytes <= i_cfg.data;
                    end
                    REG_REPLACEMENT_LENGTH: begin
                        r_rlen <= i_cfg.data[3:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== hdl/sfr_queue.sv =====
// Short job queue between the front and back parts.
// Depends on nothing beyond its parameters.
module sfr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [FW-1:0]    r_fill;

    assign o_ready = (r_fill != FW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/sfr_back.sv =====
// Back part: walks the head job one byte per cycle into the output, unless stalled.
// Depends on sfr_pkg and the channel interfaces.
module sfr_back import sfr_pkg::*; #(
    parameter int  MAX_TARGET      = DEF_MAX_TARGET,
    parameter int  MAX_REPLACEMENT = DEF_MAX_REPLACEMENT,
    localparam int SLOTS           = job_slots(MAX_TARGET, MAX_REPLACEMENT),
    localparam int JCW             = $clog2(SLOTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  logic [SLOTS*8-1:0] i_job_bytes,
    input  logic [JCW-1:0]     i_job_cnt,
    input  logic               i_job_last,
    output logic               o_pop,
    sfr_out_if.source          o_out
);

    logic           r_valid;
    logic [7:0]     r_byte;
    logic           r_present;
    logic           r_run_last;
    logic           r_end;
    logic [JCW-1:0] r_idx;

    logic       load;
    logic       is_final;
    logic       present;
    logic [7:0] sel_byte;

    always_comb begin
        load     = i_q_valid && (!r_valid || o_out.ready);
        present  = (i_job_cnt != '0);
        is_final = !present || (r_idx == i_job_cnt - 1'b1);
        sel_byte = 8'd0;
        for (int j = 0; j < SLOTS; j++) begin
            if (present && (JCW'(j) == r_idx)) begin
                sel_byte = i_job_bytes[8*j +: 8];
            end
        end
    end

    assign o_pop              = load && is_final;
    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_byte;
    assign o_out.byte_present = r_present;
    assign o_out.run_last     = r_run_last;
    assign o_out.stream_end   = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= is_final ? '0 : r_idx + 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= sel_byte;
            r_present  <= present;
            r_run_last <= is_final;
            r_end      <= is_final && i_job_last;
        end
    end

endmodule

// ===== hdl/stream_find_replace.sv =====
// Top level of the streaming find-and-replace block.
// Depends on sfr_pkg, the channel interfaces, sfr_front, sfr_queue and sfr_back.
//
// The input channel takes one stream byte per transfer, with stream_last on the
// final byte. The output channel gives one result per transfer: a byte, or on an
// empty stream end a marker with byte_present low; run_last closes the results
// of one input byte and stream_end closes the stream. The configuration channel
// is always ready and writes the target, its length, the replacement and its
// length; the user is to write it only while the block is idle (the block does
// not enforce it); writing the target or its length discards pending bytes.
// The front matches each byte against the target in the cycle of its transfer,
// so one byte is taken per cycle while the job queue has room. Results go
// through the job queue and then the output register. The back part gives one
// result per cycle while the receiver is ready, so a byte causing n results
// needs n transfers; the four-entry queue absorbs the difference. On a stall
// the output register holds its result, the queue fills and input ready falls.
// Reset empties window, queue and output; registers to 0, target length to 1.
module stream_find_replace import sfr_pkg::*; #(
    parameter int MAX_TARGET      = DEF_MAX_TARGET,
    parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfr_in_if.sink    i_in,
    sfr_cfg_if.sink   i_cfg,
    sfr_out_if.source o_out
);

    localparam int SLOTS = job_slots(MAX_TARGET, MAX_REPLACEMENT);
    localparam int JCW   = $clog2(SLOTS + 1);
    localparam int JW    = SLOTS * 8 + JCW + 1;

    logic               q_ready;
    logic               q_valid;
    logic               push;
    logic               pop;
    logic [SLOTS*8-1:0] f_bytes;
    logic [JCW-1:0]     f_cnt;
    logic               f_last;
    logic [JW-1:0]      q_data;

    sfr_front #(
        .MAX_TARGET      (MAX_TARGET),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_job_bytes (f_bytes),
        .o_job_cnt   (f_cnt),
        .o_job_last  (f_last)
    );

    sfr_queue #(
        .WIDTH (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_last, f_cnt, f_bytes}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    sfr_back #(
        .MAX_TARGET      (MAX_TARGET),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job_bytes (q_data[SLOTS*8-1:0]),
        .i_job_cnt   (q_data[SLOTS*8 +: JCW]),
        .i_job_last  (q_data[JW-1]),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

// ===== tb/sv/stream_find_replace_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stream_find_replace: directed rows, then random streams.
// Depends on sfr_pkg, the channel interfaces in sfr_ifs and the block's RTL.
module stream_find_replace_tb;
    import sfr_pkg::*;

    localparam int TOTAL_ITEMS    = 310;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int CALM_ITEMS     = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       run_last;
        logic       stream_end;
    } t_result;

    typedef enum logic [1:0] {ROW_BYTE, ROW_REG} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} t_check_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_reg    reg_idx;
        logic [63:0] value;
        logic        last;
        t_check_kind chk;
        t_result     want;
    } t_stim_row;

    localparam int NROWS = 36;
    localparam t_stim_row DIRECTED [NROWS] = '{
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h41, 1'b0, CHK_ONE, '{8'h41, 1'b1, 1'b1, 1'b0}},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h00, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b1, CHK_ONE, '{8'hFF, 1'b1, 1'b1, 1'b1}},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h00, 1'b1, CHK_ONE, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{ROW_REG, REG_TARGET_BYTES, 64'h0063_6261, 1'b0, CHK_MODEL, '0},
        '{ROW_REG, REG_TARGET_LENGTH, 64'd3, 1'b0, CHK_MODEL, '0},
        '{ROW_REG, REG_REPLACEMENT_BYTES, 64'h5958, 1'b0, CHK_MODEL, '0},
        '{ROW_REG, REG_REPLACEMENT_LENGTH, 64'd2, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h61, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h62, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h63, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h61, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h61, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h62, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h78, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h61, 1'b1, CHK_MODEL, '0},
        '{ROW_REG, REG_TARGET_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, CHK_MODEL, '0},
        '{ROW_REG, REG_TARGET_LENGTH, 64'd0, 1'b0, CHK_MODEL, '0},
        '{ROW_REG, REG_REPLACEMENT_BYTES, 64'h0807_0605_0403_0201, 1'b0, CHK_MODEL, '0},
        '{ROW_REG, REG_REPLACEMENT_LENGTH, 64'd15, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'h7F, 1'b1, CHK_ONE, '{8'h7F, 1'b1, 1'b1, 1'b1}},
        '{ROW_REG, REG_TARGET_LENGTH, 64'd15, 1'b0, CHK_MODEL, '0},
        '{ROW_REG, REG_REPLACEMENT_LENGTH, 64'd0, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_REG, REG_TARGET_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, CHK_MODEL, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b0, CHK_NONE, '0},
        '{ROW_BYTE, REG_TARGET_BYTES, 64'hFF, 1'b1, CHK_ONE, '{8'h00, 1'b0, 1'b1, 1'b1}}
    };

    logic i_clk;
    logic i_rst_n;

    sfr_in_if  in_ch ();
    sfr_out_if out_ch ();
    sfr_cfg_if cfg_ch ();

    stream_find_replace u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Predictor state: registers as written and the bytes still held back.
    logic [63:0] tgt_word;
    logic [3:0]  tgt_len_raw;
    logic [63:0] rep_word;
    logic [3:0]  rep_len_raw;
    logic [7:0]  held [8];
    int          held_n;

    t_result     due_results [$];
    int          faults;
    int          items_sent;
    int          results_seen;
    int          reg_writes;
    int          send_odds;
    int          sink_odds;
    bit          hold_request;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int tgt_span();
        int n;
        n = tgt_len_raw;
        if (n == 0) n = 1;
        if (n > DEF_MAX_TARGET) n = DEF_MAX_TARGET;
        return n;
    endfunction

    function automatic bit held_is_prefix(input int span);
        if (held_n > span) return 1'b0;
        for (int i = 0; i < held_n; i++) begin
            if (held[i] != tgt_word[8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void find_replace_byte(input logic [7:0] b, input logic last,
                                              output t_result res [$]);
        int span;
        int rlen;
        res = {};
        span = tgt_span();
        held[held_n] = b;
        held_n++;
        while (held_n > 0 && !held_is_prefix(span)) begin
            res.push_back('{held[0], 1'b1, 1'b0, 1'b0});
            for (int i = 0; i < 7; i++) held[i] = held[i+1];
            held_n--;
        end
        if (held_n == span) begin
            rlen = (rep_len_raw > DEF_MAX_REPLACEMENT) ? DEF_MAX_REPLACEMENT : rep_len_raw;
            for (int i = 0; i < rlen; i++) res.push_back('{rep_word[8*i +: 8], 1'b1, 1'b0, 1'b0});
            held_n = 0;
        end
        if (last) begin
            for (int i = 0; i < held_n; i++) res.push_back('{held[i], 1'b1, 1'b0, 1'b0});
            held_n = 0;
            if (res.size() == 0) res.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
            res[res.size()-1].stream_end = 1'b1;
        end
        if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    endfunction

    function automatic void apply_reg(input t_cfg_reg idx, input logic [63:0] val);
        case (idx)
            REG_TARGET_BYTES: begin
                tgt_word = val;
                held_n   = 0;
            end
            REG_TARGET_LENGTH: begin
                tgt_len_raw = val[3:0];
                held_n      = 0;
            end
            REG_REPLACEMENT_BYTES:  rep_word    = val;
            REG_REPLACEMENT_LENGTH: rep_len_raw = val[3:0];
            default: ;
        endcase
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] val, input bit more);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        apply_reg(idx, val);
        reg_writes++;
        if (!more) cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input t_check_kind chk,
                             input t_result want);
        t_result model_q [$];
        int gap;
        if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.stream_last <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        find_replace_byte(b, last, model_q);
        case (chk)
            CHK_MODEL: foreach (model_q[i]) due_results.push_back(model_q[i]);
            CHK_ONE:   due_results.push_back(want);
            default: ;
        endcase
        items_sent++;
    endtask

    // Bytes that cause no result may still be inside the block, so wait out its latency.
    task automatic wait_block_idle();
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_result();
        t_result want;
        results_seen++;
        if (due_results.size() == 0) begin
            $display("%0t: expected no result, got byte %02h present %0b run_last %0b end %0b",
                     $time, out_ch.out_byte, out_ch.byte_present, out_ch.run_last,
                     out_ch.stream_end);
            faults++;
        end else begin
            want = due_results.pop_front();
            if (out_ch.byte_present !== want.present || out_ch.run_last !== want.run_last ||
                out_ch.stream_end !== want.stream_end ||
                (want.present && out_ch.out_byte !== want.data)) begin
                $display("%0t: expected byte %02h present %0b run_last %0b end %0b, got %02h %0b %0b %0b",
                         $time, want.data, want.present, want.run_last, want.stream_end,
                         out_ch.out_byte, out_ch.byte_present, out_ch.run_last,
                         out_ch.stream_end);
                faults++;
            end
        end
    endtask

    initial begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) check_result();
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
                stall_left = $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("stream_find_replace_tb failed");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] tgt;
        logic [63:0] rep;
        logic [3:0]  tlen;
        logic [3:0]  rlen;
        logic [7:0]  base;
        logic [7:0]  text [$];
        int          span;
        int          pick;
        int          cut;
        int          n;
        int          phase;
        bit          calm;
        bit          close;
        bit          last;

        tgt_word     = '0;
        tgt_len_raw  = 4'd1;
        rep_word     = '0;
        rep_len_raw  = 4'd0;
        held_n       = 0;
        faults       = 0;
        items_sent   = 0;
        results_seen = 0;
        reg_writes   = 0;
        send_odds    = 4;
        sink_odds    = 4;
        hold_request = 1'b0;
        phase        = 0;

        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= '0;
        in_ch.stream_last <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_TARGET_BYTES;
        cfg_ch.data       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NROWS; r++) begin
            if (DIRECTED[r].kind == ROW_REG) begin
                if (r == 0 || DIRECTED[r-1].kind != ROW_REG) wait_block_idle();
                write_reg(DIRECTED[r].reg_idx, DIRECTED[r].value,
                          r + 1 < NROWS && DIRECTED[r+1].kind == ROW_REG);
            end else begin
                send_byte(DIRECTED[r].value[7:0], DIRECTED[r].last, DIRECTED[r].chk,
                          DIRECTED[r].want);
            end
        end

        while (items_sent < TOTAL_ITEMS) begin
            phase++;
            calm = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
            wait_block_idle();
            send_odds = calm ? 0 : 3 * $urandom_range(0, 2);
            sink_odds = calm ? 0 : 3 * $urandom_range(0, 2);

            rep  = {$urandom, $urandom};
            rlen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 8));
            if (!calm && phase > 1 && $urandom_range(0, 3) == 0) begin
                // The pending bytes survive a change of the replacement alone.
                write_reg(REG_REPLACEMENT_BYTES, rep, 1'b1);
                write_reg(REG_REPLACEMENT_LENGTH, {60'd0, rlen}, 1'b0);
            end else begin
                base = 8'($urandom_range(0, 255));
                for (int i = 0; i < 8; i++) begin
                    tgt[8*i +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                               : 8'(base + $urandom_range(0, 1));
                end
                tlen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
                write_reg(REG_TARGET_BYTES, tgt, 1'b1);
                write_reg(REG_TARGET_LENGTH, {60'd0, tlen}, 1'b1);
                write_reg(REG_REPLACEMENT_BYTES, rep, 1'b1);
                write_reg(REG_REPLACEMENT_LENGTH, {60'd0, rlen}, 1'b0);
            end

            n = $urandom_range(4, 24);
            if (phase == 3) begin
                hold_request = 1'b1;
                send_odds    = 0;
                n            = $urandom_range(16, 24);
            end

            span = tgt_span();
            text = {};
            while (text.size() < n) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    for (int i = 0; i < span; i++) text.push_back(tgt_word[8*i +: 8]);
                end else if (pick < 6 && span > 1) begin
                    cut = $urandom_range(1, span - 1);
                    for (int i = 0; i < cut; i++) text.push_back(tgt_word[8*i +: 8]);
                end else if (pick < 8) begin
                    cut = $urandom_range(0, span - 1);
                    text.push_back(tgt_word[8*cut +: 8]);
                end else begin
                    text.push_back(8'($urandom_range(0, 255)));
                end
            end

            close = calm || ($urandom_range(0, 3) != 0);
            for (int i = 0; i < text.size(); i++) begin
                last = (i == text.size() - 1 && close) || ($urandom_range(0, 29) == 0);
                send_byte(text[i], last, CHK_MODEL, '0);
            end
        end

        wait_block_idle();
        if (due_results.size() != 0) faults++;
        $display("Run covered %0d stream bytes in %0d random phases, %0d register writes,",
                 items_sent, phase, reg_writes);
        $display("and %0d output results were checked with %0d faults.", results_seen, faults);
        if (faults == 0) begin
            $display("stream_find_replace_tb passed");
        end else begin
            $display("stream_find_replace_tb failed");
        end
        $finish;
    end

endmodule
